@@ hdl/tzs_pkg.sv @@
// Package for the timed zone sequencer: action codes, step entry layout,
// timing constants and the result record.
// No dependencies.
package tzs_pkg;

  localparam int unsigned STEP_SLOTS = 8;
  localparam int unsigned RELAY_W    = 8;

  localparam logic [2:0] ACT_TICK        = 3'd0;
  localparam logic [2:0] ACT_LOAD_STEP   = 3'd1;
  localparam logic [2:0] ACT_START_PROG  = 3'd2;
  localparam logic [2:0] ACT_START_ZONE  = 3'd3;
  localparam logic [2:0] ACT_STOP        = 3'd4;
  localparam logic [2:0] ACT_SET_DEFAULT = 3'd5;

  // Last millisecond count inside one minute and inside one second.
  localparam logic [15:0] MS_LAST_OF_MINUTE = 16'd59999;
  localparam logic [15:0] MS_LAST_OF_SECOND = 16'd999;

  localparam logic [15:0] RESET_DEFAULT_MINUTES = 16'd10;
  localparam logic [3:0]  MAX_STEP_COUNT        = 4'd8;

  typedef struct packed {
    logic [2:0]  zone;
    logic [15:0] minutes;
  } step_t;

  typedef struct packed {
    logic [2:0] current_zone;
    logic [2:0] step_number;
    logic       filling;
    logic       running;
    logic [7:0] relay_drive;
    logic [7:0] relay_bits;
  } result_t;

endpackage

@@ hdl/timed_zone_sequencer.sv @@
// Timed zone sequencer top level: program stepping, timing and output skid stage.
// Depends on tzs_pkg.
//
//   port group   dir   accepted when          payload
//   s_*          in    s_tvalid & s_tready    tuser action, tdata step fields
//   m_*          out   m_tvalid & m_tready    tdata status, tlast finished
//   cfg_wr_*     in    cfg_wr_en              delay_seconds
//
// Every item is handled combinationally; its result is registered and shows on
// m_*, so one item can be taken in every cycle while s_tready is high.
// A two-entry output stage (result register plus skid register) keeps s_tready
// high for one more item while a result waits; s_tready drops only when both hold one.
// Reset is synchronous, clears the program state and sets every zone default to ten.
module timed_zone_sequencer #(
  parameter int unsigned ZONE_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // action
  input  logic [31:0] s_tdata,   // index, zone, minutes, step_count, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // relay_bits, relay_drive, running, filling,
                                 // step_number, current_zone
  output logic        m_tlast,   // finished
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import tzs_pkg::*;

  logic [2:0]  in_index;
  logic [2:0]  in_zone;
  logic [15:0] in_minutes;
  logic [3:0]  in_count;
  logic        accept;

  logic [15:0] delay_seconds;
  logic        run_flag, run_flag_next;
  logic        delay_flag, delay_flag_next;
  logic [2:0]  step_pos, step_pos_next;
  logic [3:0]  active_length, active_length_next;
  logic [15:0] ms_count, ms_count_next;
  logic [15:0] unit_count, unit_count_next;
  logic [15:0] target_minutes, target_minutes_next;
  logic [2:0]  cur_zone, cur_zone_next;
  step_t       active_steps [STEP_SLOTS];
  step_t       active_steps_next [STEP_SLOTS];
  step_t       staged_steps [STEP_SLOTS];
  step_t       staged_steps_next [STEP_SLOTS];
  logic [15:0] zone_default [STEP_SLOTS];
  logic [15:0] zone_default_next [STEP_SLOTS];

  logic        done;
  logic        start_step;
  step_t       start_entry;
  step_t       read_entry;
  logic [2:0]  read_addr;
  logic [3:0]  pos_inc;
  logic        ms_wrap;
  logic [15:0] ms_inc;
  logic [15:0] unit_inc;
  logic [3:0]  sat_count;
  logic        in_zone_ok;
  logic        cur_zone_ok;
  result_t     result;
  result_t     out_reg, skid_reg;
  logic        out_valid, skid_valid;
  logic        out_last, skid_last;

  assign in_index   = s_tdata[2:0];
  assign in_zone    = s_tdata[5:3];
  assign in_minutes = s_tdata[21:6];
  assign in_count   = s_tdata[25:22];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  assign pos_inc    = {1'b0, step_pos} + 4'd1;
  assign read_addr  = delay_flag ? step_pos : pos_inc[2:0];
  assign read_entry = active_steps[read_addr];
  assign ms_wrap    = delay_flag ? (ms_count == MS_LAST_OF_SECOND)
                                 : (ms_count == MS_LAST_OF_MINUTE);
  assign ms_inc     = ms_wrap ? 16'd0 : ms_count + 16'd1;
  assign unit_inc   = unit_count + {15'd0, ms_wrap};
  assign sat_count  = (in_count > MAX_STEP_COUNT) ? MAX_STEP_COUNT : in_count;
  assign in_zone_ok = ({2'b00, in_zone} < 5'(ZONE_COUNT));

  always_comb begin
    run_flag_next       = run_flag;
    delay_flag_next     = delay_flag;
    step_pos_next       = step_pos;
    active_length_next  = active_length;
    ms_count_next       = ms_count;
    unit_count_next     = unit_count;
    target_minutes_next = target_minutes;
    cur_zone_next       = cur_zone;
    active_steps_next   = active_steps;
    staged_steps_next   = staged_steps;
    zone_default_next   = zone_default;
    done                = 1'b0;
    start_step          = 1'b0;
    start_entry         = read_entry;
    if (accept) begin
      unique case (s_tuser)
        ACT_TICK: begin
          if (run_flag) begin
            ms_count_next   = ms_inc;
            unit_count_next = unit_inc;
            if (delay_flag) begin
              if (unit_inc >= delay_seconds) begin
                start_step = 1'b1;
              end
            end else if (unit_inc >= target_minutes) begin
              if (pos_inc >= active_length) begin
                run_flag_next   = 1'b0;
                delay_flag_next = 1'b0;
                step_pos_next   = 3'd0;
                done            = 1'b1;
              end else begin
                step_pos_next = pos_inc[2:0];
                if (delay_seconds != 16'd0) begin
                  delay_flag_next = 1'b1;
                  ms_count_next   = 16'd0;
                  unit_count_next = 16'd0;
                  cur_zone_next   = read_entry.zone;
                end else begin
                  start_step = 1'b1;
                end
              end
            end
          end
        end
        ACT_LOAD_STEP: begin
          staged_steps_next[in_index] = '{zone: in_zone, minutes: in_minutes};
        end
        ACT_START_PROG: begin
          if (run_flag) begin
            run_flag_next   = 1'b0;
            delay_flag_next = 1'b0;
            step_pos_next   = 3'd0;
          end
          if (sat_count != 4'd0) begin
            active_steps_next  = staged_steps;
            active_length_next = sat_count;
            step_pos_next      = 3'd0;
            run_flag_next      = 1'b1;
            start_step         = 1'b1;
            start_entry        = staged_steps[0];
          end
        end
        ACT_START_ZONE: begin
          if (in_zone_ok) begin
            active_steps_next[0] = '{zone: in_zone, minutes: in_minutes};
            active_length_next   = 4'd1;
            step_pos_next        = 3'd0;
            run_flag_next        = 1'b1;
            start_step           = 1'b1;
            start_entry          = '{zone: in_zone, minutes: in_minutes};
          end
        end
        ACT_STOP: begin
          if (run_flag) begin
            run_flag_next   = 1'b0;
            delay_flag_next = 1'b0;
            step_pos_next   = 3'd0;
          end
        end
        ACT_SET_DEFAULT: begin
          if (in_zone_ok) begin
            zone_default_next[in_zone] = in_minutes;
          end
        end
        default: begin
        end
      endcase
    end
    if (start_step) begin
      delay_flag_next     = 1'b0;
      ms_count_next       = 16'd0;
      unit_count_next     = 16'd0;
      cur_zone_next       = start_entry.zone;
      target_minutes_next = (start_entry.minutes == 16'd0) ?
                            zone_default[start_entry.zone] : start_entry.minutes;
    end
  end

  assign cur_zone_ok = ({2'b00, cur_zone_next} < 5'(ZONE_COUNT));

  always_comb begin
    result = '0;
    if (run_flag_next && !delay_flag_next && cur_zone_ok) begin
      result.relay_bits = 8'd1 << cur_zone_next;
    end
    result.relay_drive = ~result.relay_bits;
    result.running     = run_flag_next;
    result.filling     = run_flag_next && delay_flag_next;
    if (run_flag_next) begin
      result.step_number  = step_pos_next;
      result.current_zone = cur_zone_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_seconds  <= 16'd0;
      run_flag       <= 1'b0;
      delay_flag     <= 1'b0;
      step_pos       <= 3'd0;
      active_length  <= 4'd0;
      ms_count       <= 16'd0;
      unit_count     <= 16'd0;
      target_minutes <= 16'd0;
      cur_zone       <= 3'd0;
      for (int i = 0; i < STEP_SLOTS; i++) begin
        active_steps[i] <= '0;
        staged_steps[i] <= '0;
        zone_default[i] <= RESET_DEFAULT_MINUTES;
      end
    end else begin
      if (cfg_wr_en) begin
        delay_seconds <= cfg_wr_data;
      end
      run_flag       <= run_flag_next;
      delay_flag     <= delay_flag_next;
      step_pos       <= step_pos_next;
      active_length  <= active_length_next;
      ms_count       <= ms_count_next;
      unit_count     <= unit_count_next;
      target_minutes <= target_minutes_next;
      cur_zone       <= cur_zone_next;
      active_steps   <= active_steps_next;
      staged_steps   <= staged_steps_next;
      zone_default   <= zone_default_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_reg  <= skid_reg;
        out_last <= skid_last;
      end else begin
        out_reg  <= result;
        out_last <= done;
      end
    end else if (accept) begin
      skid_reg  <= result;
      skid_last <= done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg;
  assign m_tlast  = out_last;

endmodule

@@ verif/timed_zone_sequencer_tb.sv @@
// Self-checking testbench for timed_zone_sequencer: a queue-fed stream driver,
// a result monitor and a behavioral predictor of the step sequencing and timing.
// Depends on tzs_pkg and the timed_zone_sequencer RTL.
`timescale 1ns / 100ps

module timed_zone_sequencer_tb;
  import tzs_pkg::*;

  localparam int unsigned ZONE_COUNT   = 8;
  localparam logic [2:0]  ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0]  ACT_UNUSED_7 = 3'd7;
  localparam logic [31:0] MS_PER_MINUTE = 32'(MS_LAST_OF_MINUTE) + 32'd1;
  localparam logic [31:0] MS_PER_SECOND = 32'(MS_LAST_OF_SECOND) + 32'd1;
  localparam int          PHASE_ITEMS   = 220;

  typedef struct {
    logic [2:0]  action;
    logic [2:0]  index;
    logic [2:0]  zone;
    logic [15:0] minutes;
    logic [3:0]  count;
  } zone_cmd_t;

  typedef struct {
    result_t r;
    logic    finished;
  } seq_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [2:0]  s_tuser = '0;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  zone_cmd_t   pending_q[$];
  seq_status_t status_q[$];
  zone_cmd_t   cur_cmd;
  int          gap_cnt = 0;
  int          stall_cnt = 0;
  bit          calm = 1'b0;
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          programs_done = 0;
  int          settings_used = 1;

  logic [15:0] delay_m;
  logic        run_m;
  logic        fill_m;
  logic [2:0]  pos_m;
  logic [3:0]  len_m;
  logic [31:0] elapsed_m;
  logic [31:0] target_m;
  logic [7:0]  relay_m;
  step_t       active_m[STEP_SLOTS];
  step_t       staged_m[STEP_SLOTS];
  logic [15:0] dflt_m[STEP_SLOTS];

  timed_zone_sequencer #(.ZONE_COUNT(ZONE_COUNT)) u_top (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic start_step();
    step_t       e;
    logic [15:0] m;
    e = active_m[pos_m];
    m = e.minutes;
    if (m == 16'd0) m = dflt_m[e.zone];
    fill_m = 1'b0;
    target_m = 32'(m) * MS_PER_MINUTE;
    elapsed_m = '0;
    if (e.zone < ZONE_COUNT) relay_m[e.zone] = 1'b1;
  endtask

  task automatic halt_program();
    relay_m = '0;
    run_m = 1'b0;
    fill_m = 1'b0;
    pos_m = '0;
  endtask

  task automatic launch_program(input logic [3:0] n);
    if (run_m) halt_program();
    if (n != 4'd0) begin
      len_m = n;
      pos_m = '0;
      run_m = 1'b1;
      start_step();
    end
  endtask

  task automatic step_sequencer(input zone_cmd_t c);
    seq_status_t s;
    logic        done;
    logic [3:0]  n;
    int          nxt;
    done = 1'b0;
    case (c.action)
      ACT_TICK: begin
        if (run_m) begin
          if (elapsed_m != '1) elapsed_m = elapsed_m + 32'd1;
          if (fill_m) begin
            if (elapsed_m >= 32'(delay_m) * MS_PER_SECOND) start_step();
          end else if (elapsed_m >= target_m) begin
            if (active_m[pos_m].zone < ZONE_COUNT) relay_m[active_m[pos_m].zone] = 1'b0;
            nxt = int'(pos_m) + 1;
            if (nxt >= int'(len_m)) begin
              run_m = 1'b0;
              fill_m = 1'b0;
              pos_m = '0;
              done = 1'b1;
            end else begin
              pos_m = nxt[2:0];
              if (delay_m != 16'd0) begin
                fill_m = 1'b1;
                elapsed_m = '0;
              end else begin
                start_step();
              end
            end
          end
        end
      end
      ACT_LOAD_STEP: begin
        staged_m[c.index] = {c.zone, c.minutes};
      end
      ACT_START_PROG: begin
        n = (c.count > MAX_STEP_COUNT) ? MAX_STEP_COUNT : c.count;
        if (n != 4'd0) active_m = staged_m;
        launch_program(n);
      end
      ACT_START_ZONE: begin
        if (c.zone < ZONE_COUNT) begin
          active_m[0] = {c.zone, c.minutes};
          launch_program(4'd1);
        end
      end
      ACT_STOP: begin
        if (run_m) halt_program();
      end
      ACT_SET_DEFAULT: begin
        if (c.zone < ZONE_COUNT) dflt_m[c.zone] = c.minutes;
      end
      default: begin
      end
    endcase
    s.r.relay_bits   = relay_m;
    s.r.relay_drive  = ~relay_m;
    s.r.running      = run_m;
    s.r.filling      = run_m & fill_m;
    s.r.step_number  = run_m ? pos_m : 3'd0;
    s.r.current_zone = run_m ? active_m[pos_m].zone : 3'd0;
    s.finished       = done;
    status_q.push_back(s);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("tb: mismatch in %s at result %0d: got %0h, expected %0h",
             what, results_seen, got, want);
    errors++;
  endtask

  task automatic add_item(input logic [2:0] action, input logic [2:0] index,
                          input logic [2:0] zone, input logic [15:0] minutes,
                          input logic [3:0] count);
    zone_cmd_t c;
    c.action = action;
    c.index = index;
    c.zone = zone;
    c.minutes = minutes;
    c.count = count;
    pending_q.push_back(c);
  endtask

  task automatic add_ticks(input int n);
    for (int i = 0; i < n; i++) add_item(ACT_TICK, 3'($urandom), 3'($urandom),
                                         16'($urandom), 4'($urandom));
  endtask

  // Mostly complete programs with short steps, mixed with raw random items.
  task automatic add_random_traffic(input int budget);
    int          planned;
    int          n;
    int          t;
    logic [2:0]  z;
    logic [15:0] m;
    planned = 0;
    while (planned < budget) begin
      if ($urandom_range(0, 3) != 0) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          z = 3'($urandom);
          m = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd0;
          if ($urandom_range(0, 4) != 0) begin
            add_item(ACT_SET_DEFAULT, 3'($urandom), z,
                     ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd0, 4'($urandom));
            planned++;
          end
          add_item(ACT_LOAD_STEP, 3'(i), z, m, 4'($urandom));
          planned++;
        end
        if ($urandom_range(0, 9) == 0) begin
          add_item(ACT_START_ZONE, 3'($urandom), 3'($urandom),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0, 4'($urandom));
        end else begin
          add_item(ACT_START_PROG, 3'($urandom), 3'($urandom), 16'($urandom),
                   ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) :
                   ($urandom_range(0, 19) == 0) ? 4'd0 : 4'(n));
        end
        planned++;
        t = $urandom_range(0, 14);
        add_ticks(t);
        planned += t;
        if ($urandom_range(0, 9) == 0) begin
          add_item(ACT_STOP, 3'($urandom), 3'($urandom), 16'($urandom), 4'($urandom));
          planned++;
        end
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          add_item(3'($urandom), 3'($urandom), 3'($urandom), 16'($urandom),
                   4'($urandom));
          planned++;
        end
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() != 0 || s_tvalid || status_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delay(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    delay_m = v;
  endtask

  always @(posedge clk) begin : feed
    zone_cmd_t nxt_cmd;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        step_sequencer(cur_cmd);
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_cnt != 0) begin
          gap_cnt <= gap_cnt - 1;
          s_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          nxt_cmd = pending_q.pop_front();
          cur_cmd = nxt_cmd;
          s_tuser <= nxt_cmd.action;
          s_tdata <= {6'd0, nxt_cmd.count, nxt_cmd.minutes, nxt_cmd.zone, nxt_cmd.index};
          s_tvalid <= 1'b1;
          gap_cnt <= calm ? 0 : idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    seq_status_t want;
    result_t     got;
    if (rst) begin
      m_tready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (status_q.size() == 0) begin
          note_mismatch("unexpected result", 32'(m_tdata), 32'd0);
        end else begin
          want = status_q.pop_front();
          got = m_tdata;
          if (got.relay_bits !== want.r.relay_bits)
            note_mismatch("relay_bits", 32'(got.relay_bits), 32'(want.r.relay_bits));
          if (got.relay_drive !== want.r.relay_drive)
            note_mismatch("relay_drive", 32'(got.relay_drive), 32'(want.r.relay_drive));
          if (got.running !== want.r.running)
            note_mismatch("running", 32'(got.running), 32'(want.r.running));
          if (got.filling !== want.r.filling)
            note_mismatch("filling", 32'(got.filling), 32'(want.r.filling));
          if (got.step_number !== want.r.step_number)
            note_mismatch("step_number", 32'(got.step_number), 32'(want.r.step_number));
          if (got.current_zone !== want.r.current_zone)
            note_mismatch("current_zone", 32'(got.current_zone), 32'(want.r.current_zone));
          if (m_tlast !== want.finished)
            note_mismatch("finished", 32'(m_tlast), 32'(want.finished));
          if (want.finished) programs_done++;
        end
      end
      if (stall_cnt != 0) begin
        m_tready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        m_tready <= 1'b1;
        stall_cnt <= (calm || $urandom_range(0, 3) != 0) ? 0 : idle_len();
      end
    end
  end

  initial begin
    #250000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [15:0] phase_delay[4];
    delay_m = '0;
    run_m = 1'b0;
    fill_m = 1'b0;
    pos_m = '0;
    len_m = '0;
    elapsed_m = '0;
    target_m = '0;
    relay_m = '0;
    for (int i = 0; i < STEP_SLOTS; i++) begin
      active_m[i] = '0;
      staged_m[i] = '0;
      dflt_m[i] = RESET_DEFAULT_MINUTES;
    end
    phase_delay[0] = 16'd1;
    phase_delay[1] = 16'hFFFF;
    phase_delay[2] = 16'd0;
    phase_delay[3] = 16'($urandom_range(2, 5));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed items with the reset value of the pause.
    @(negedge clk);
    add_item(ACT_TICK, 3'd7, 3'd7, 16'hFFFF, 4'hF);
    add_item(ACT_STOP, 3'd0, 3'd0, 16'd0, 4'd0);
    add_item(ACT_UNUSED_6, 3'd7, 3'd7, 16'hFFFF, 4'hF);
    add_item(ACT_UNUSED_7, 3'd2, 3'd5, 16'h1234, 4'd3);
    add_item(ACT_START_PROG, 3'd0, 3'd0, 16'd0, 4'd0);
    add_item(ACT_START_ZONE, 3'd0, 3'd4, 16'd0, 4'd0);
    add_item(ACT_TICK, 3'd0, 3'd0, 16'd0, 4'd0);
    add_item(ACT_START_ZONE, 3'd0, 3'd1, 16'hFFFF, 4'd0);
    add_item(ACT_START_PROG, 3'd0, 3'd0, 16'd0, 4'd0);
    add_item(ACT_SET_DEFAULT, 3'd0, 3'd0, 16'd0, 4'd0);
    add_item(ACT_SET_DEFAULT, 3'd0, 3'd5, 16'd0, 4'd0);
    add_item(ACT_SET_DEFAULT, 3'd0, 3'd7, 16'hFFFF, 4'd0);
    add_item(ACT_LOAD_STEP, 3'd0, 3'd0, 16'd0, 4'd0);
    add_item(ACT_LOAD_STEP, 3'd1, 3'd5, 16'd0, 4'd0);
    add_item(ACT_LOAD_STEP, 3'd7, 3'd7, 16'hFFFF, 4'd0);
    add_item(ACT_START_PROG, 3'd0, 3'd0, 16'd0, 4'hF);
    add_item(ACT_LOAD_STEP, 3'd2, 3'd3, 16'd2, 4'd0);
    add_ticks(8);
    add_item(ACT_STOP, 3'd0, 3'd0, 16'd0, 4'd0);
    add_item(ACT_START_PROG, 3'd0, 3'd0, 16'd0, 4'd1);
    add_item(ACT_TICK, 3'd0, 3'd0, 16'd0, 4'd0);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_delay(phase_delay[p]);
      settings_used++;
      calm = (p == 2);
      @(negedge clk);
      add_random_traffic(PHASE_ITEMS);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (status_q.size() != 0) note_mismatch("results never produced", status_q.size(), 0);
    $display("tb: %0d items over %0d pause settings, %0d results checked,",
             items_sent, settings_used, results_seen);
    $display("tb: %0d programs ran to completion", programs_done);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
